// ===== rtl/pli_pkg.sv =====
package pli_pkg;

    // default sizing
    localparam int unsigned LIST_DEPTH  = 32;
    localparam int unsigned ID_BITS     = 16;

    // fixed port widths
    localparam int unsigned OP_BITS     = 2;
    localparam int unsigned DOC_ID_BITS = 16;

    // request opcodes
    localparam logic [OP_BITS-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OP_BITS-1:0] OP_APPEND_B = 2'd1;
    localparam logic [OP_BITS-1:0] OP_COMPUTE  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic append_a;
        logic append_b;
        logic emit_empty;
        logic walk_start;
        logic walk_step;
        logic copy_start;
        logic copy_a;
        logic copy_b;
        logic rank_start;
        logic key_sel;
        logic key_load;
        logic scan_step;
        logic rank_store;
        logic emit_start;
        logic emit;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic both_empty;
        logic a_lt;
        logic b_lt;
        logic n_zero;
        logic i_lt_n;
        logic j_lt_n;
        logic p_lt_n;
    } t_stat;

endpackage

// ===== rtl/pli_ctrl.sv =====
module pli_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [pli_pkg::OP_BITS-1:0]      i_op,
    input  pli_pkg::t_stat                   i_stat,
    output pli_pkg::t_cmd                    o_cmd,
    output logic                             busy
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_WALK_RD  = 13'b0000000000010,
        S_WALK_CMP = 13'b0000000000100,
        S_COPYA_RD = 13'b0000000001000,
        S_COPYA_WR = 13'b0000000010000,
        S_COPYB_RD = 13'b0000000100000,
        S_COPYB_WR = 13'b0000001000000,
        S_KEY_RD   = 13'b0000010000000,
        S_KEY_LD   = 13'b0000100000000,
        S_SCAN_RD  = 13'b0001000000000,
        S_SCAN_CMP = 13'b0010000000000,
        S_EMIT_RD  = 13'b0100000000000,
        S_EMIT_OUT = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op)
                        pli_pkg::OP_APPEND_A: o_cmd.append_a = 1'b1;
                        pli_pkg::OP_APPEND_B: o_cmd.append_b = 1'b1;
                        pli_pkg::OP_COMPUTE: begin
                            if (i_stat.both_empty) begin
                                o_cmd.emit_empty = 1'b1;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                n_state          = S_WALK_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK_RD: begin
                if (i_stat.a_lt && i_stat.b_lt) begin
                    n_state = S_WALK_CMP;
                end else if (!i_stat.n_zero) begin
                    o_cmd.rank_start = 1'b1;
                    n_state          = S_KEY_RD;
                end else begin
                    o_cmd.copy_start = 1'b1;
                    n_state          = S_COPYA_RD;
                end
            end
            S_WALK_CMP: begin
                o_cmd.walk_step = 1'b1;
                n_state         = S_WALK_RD;
            end
            S_COPYA_RD: begin
                n_state = i_stat.a_lt ? S_COPYA_WR : S_COPYB_RD;
            end
            S_COPYA_WR: begin
                o_cmd.copy_a = 1'b1;
                n_state      = S_COPYA_RD;
            end
            S_COPYB_RD: begin
                if (i_stat.b_lt) begin
                    n_state = S_COPYB_WR;
                end else begin
                    o_cmd.rank_start = 1'b1;
                    n_state          = S_KEY_RD;
                end
            end
            S_COPYB_WR: begin
                o_cmd.copy_b = 1'b1;
                n_state      = S_COPYB_RD;
            end
            S_KEY_RD: begin
                o_cmd.key_sel = 1'b1;
                if (i_stat.i_lt_n) begin
                    n_state = S_KEY_LD;
                end else begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_EMIT_RD;
                end
            end
            S_KEY_LD: begin
                o_cmd.key_load = 1'b1;
                n_state        = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (i_stat.j_lt_n) begin
                    n_state = S_SCAN_CMP;
                end else begin
                    o_cmd.rank_store = 1'b1;
                    n_state          = S_KEY_RD;
                end
            end
            S_SCAN_CMP: begin
                o_cmd.scan_step = 1'b1;
                n_state         = S_SCAN_RD;
            end
            S_EMIT_RD: begin
                if (i_stat.p_lt_n) begin
                    n_state = S_EMIT_OUT;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_EMIT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== rtl/pli_dp.sv =====
module pli_dp #(
    parameter int unsigned LIST_DEPTH = pli_pkg::LIST_DEPTH,
    parameter int unsigned ID_BITS    = pli_pkg::ID_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [pli_pkg::DOC_ID_BITS-1:0]    i_doc_id,
    input  pli_pkg::t_cmd                      i_cmd,
    output pli_pkg::t_stat                     o_stat,
    output logic                               o_strobe,
    output logic [pli_pkg::DOC_ID_BITS-1:0]    o_out_id,
    output logic                               o_is_last,
    output logic                               o_empty_answer,
    output logic                               o_was_common,
    output logic                               o_overflow
);

    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned BD = 2 * LIST_DEPTH;
    localparam int unsigned BW = $clog2(BD);
    localparam int unsigned NW = $clog2(BD + 1);
    localparam int unsigned DW = pli_pkg::DOC_ID_BITS;

    // list, work buffer and sorted memories
    logic [ID_BITS-1:0] r_list_a [LIST_DEPTH];
    logic [ID_BITS-1:0] r_list_b [LIST_DEPTH];
    logic [ID_BITS-1:0] r_buf    [BD];
    logic [ID_BITS-1:0] r_sorted [BD];

    // registered read data
    logic [ID_BITS-1:0] r_xd, r_yd, r_bd, r_sd, r_key;

    // counters and flags
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_a, n_a, r_b, n_b;
    logic [NW-1:0] r_n, n_n, r_i, n_i, r_j, n_j, r_p, n_p, r_rank, n_rank;
    logic          r_drop, n_drop, r_common, n_common;

    // output registers
    logic          r_strobe, n_strobe;
    logic [DW-1:0] r_oid, n_oid;
    logic          r_last, n_last, r_empty, n_empty, r_ocommon, n_ocommon, r_oovf, n_oovf;

    logic [ID_BITS-1:0] id_in;
    logic               full_a, full_b, walk_eq, buf_we, scan_hit;
    logic [ID_BITS-1:0] buf_wd;
    logic [NW-1:0]      buf_ra;

    assign id_in    = ID_BITS'(i_doc_id);
    assign full_a   = (r_cnt_a == CW'(LIST_DEPTH));
    assign full_b   = (r_cnt_b == CW'(LIST_DEPTH));
    assign walk_eq  = (r_xd == r_yd);
    assign buf_we   = (i_cmd.walk_step && walk_eq) || i_cmd.copy_a || i_cmd.copy_b;
    assign buf_wd   = i_cmd.copy_b ? r_yd : r_xd;
    assign buf_ra   = i_cmd.key_sel ? r_i : r_j;
    assign scan_hit = (r_bd < r_key) || ((r_bd == r_key) && (r_j < r_i));

    // status back to the controller
    assign o_stat.both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign o_stat.a_lt       = (r_a < r_cnt_a);
    assign o_stat.b_lt       = (r_b < r_cnt_b);
    assign o_stat.n_zero     = (r_n == '0);
    assign o_stat.i_lt_n     = (r_i < r_n);
    assign o_stat.j_lt_n     = (r_j < r_n);
    assign o_stat.p_lt_n     = (r_p < r_n);

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.append_a && !full_a) begin
            r_list_a[r_cnt_a[AW-1:0]] <= id_in;
        end
        if (i_cmd.append_b && !full_b) begin
            r_list_b[r_cnt_b[AW-1:0]] <= id_in;
        end
        if (buf_we) begin
            r_buf[r_n[BW-1:0]] <= buf_wd;
        end
        if (i_cmd.rank_store) begin
            r_sorted[r_rank[BW-1:0]] <= r_key;
        end
        r_xd <= r_list_a[r_a[AW-1:0]];
        r_yd <= r_list_b[r_b[AW-1:0]];
        r_bd <= r_buf[buf_ra[BW-1:0]];
        r_sd <= r_sorted[r_p[BW-1:0]];
        if (i_cmd.key_load) begin
            r_key <= r_bd;
        end
    end

    // counter and pointer updates
    always_comb begin
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_drop   = r_drop;
        n_a      = r_a;
        n_b      = r_b;
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_p      = r_p;
        n_rank   = r_rank;
        n_common = r_common;
        if (i_cmd.append_a) begin
            if (full_a) n_drop = 1'b1;
            else        n_cnt_a = r_cnt_a + CW'(1);
        end
        if (i_cmd.append_b) begin
            if (full_b) n_drop = 1'b1;
            else        n_cnt_b = r_cnt_b + CW'(1);
        end
        if (i_cmd.walk_start) begin
            n_a      = '0;
            n_b      = '0;
            n_n      = '0;
            n_common = 1'b1;
        end
        if (i_cmd.walk_step) begin
            if (walk_eq) begin
                n_n = r_n + NW'(1);
                n_a = r_a + CW'(1);
                n_b = r_b + CW'(1);
            end else if (r_xd > r_yd) begin
                n_b = r_b + CW'(1);
            end else begin
                n_a = r_a + CW'(1);
            end
        end
        if (i_cmd.copy_start) begin
            n_a      = '0;
            n_b      = '0;
            n_common = 1'b0;
        end
        if (i_cmd.copy_a) begin
            n_n = r_n + NW'(1);
            n_a = r_a + CW'(1);
        end
        if (i_cmd.copy_b) begin
            n_n = r_n + NW'(1);
            n_b = r_b + CW'(1);
        end
        if (i_cmd.rank_start) begin
            n_i = '0;
        end
        if (i_cmd.key_load) begin
            n_j    = '0;
            n_rank = '0;
        end
        if (i_cmd.scan_step) begin
            n_j = r_j + NW'(1);
            if (scan_hit) n_rank = r_rank + NW'(1);
        end
        if (i_cmd.rank_store) begin
            n_i = r_i + NW'(1);
        end
        if (i_cmd.emit_start) begin
            n_p = '0;
        end
        if (i_cmd.emit) begin
            n_p = r_p + NW'(1);
        end
        if (i_cmd.finish) begin
            n_cnt_a = '0;
            n_cnt_b = '0;
        end
    end

    // result register
    always_comb begin
        n_strobe  = i_cmd.emit || i_cmd.emit_empty;
        n_oid     = r_oid;
        n_last    = r_last;
        n_empty   = r_empty;
        n_ocommon = r_ocommon;
        n_oovf    = r_oovf;
        if (i_cmd.emit_empty) begin
            n_oid     = '0;
            n_last    = 1'b1;
            n_empty   = 1'b1;
            n_ocommon = 1'b0;
            n_oovf    = r_drop;
        end else if (i_cmd.emit) begin
            n_oid     = DW'(r_sd);
            n_last    = ((r_p + NW'(1)) == r_n);
            n_empty   = 1'b0;
            n_ocommon = r_common;
            n_oovf    = r_drop;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_drop   <= 1'b0;
            r_a      <= '0;
            r_b      <= '0;
            r_n      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_p      <= '0;
            r_rank   <= '0;
            r_common <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_drop   <= n_drop;
            r_a      <= n_a;
            r_b      <= n_b;
            r_n      <= n_n;
            r_i      <= n_i;
            r_j      <= n_j;
            r_p      <= n_p;
            r_rank   <= n_rank;
            r_common <= n_common;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_oid     <= n_oid;
        r_last    <= n_last;
        r_empty   <= n_empty;
        r_ocommon <= n_ocommon;
        r_oovf    <= n_oovf;
    end

    assign o_strobe       = r_strobe;
    assign o_out_id       = r_oid;
    assign o_is_last      = r_last;
    assign o_empty_answer = r_empty;
    assign o_was_common   = r_ocommon;
    assign o_overflow     = r_oovf;

endmodule

// ===== rtl/posting_list_intersect.sv =====
// Posting list intersection with merge fallback.
// Requests: start with i_op and i_doc_id, taken at an edge where start is high
// and busy is low. Op append-first / append-second stores one id while busy
// stays low, so loads run at one per cycle; a load into a full list is
// dropped and sets the sticky overflow flag.
// Op compute raises busy, walks both lists with two pointers, copies both
// lists into the work buffer when nothing matched, ranks the n collected ids
// by scanning the buffer once per id over its single read port, then emits
// the results one at a time from the sorted memory. Worst case n = 2*LIST_DEPTH.
// Results appear on o_out_id and the flags for one cycle with o_strobe high;
// the receiver cannot stall them. The final result has o_is_last set, and
// busy falls in the cycle after the one that shows it. With both lists empty
// a compute gives a single empty-answer result in the following cycle and busy stays low.
// Both lists are emptied after each compute; overflow is cleared only by reset.
// Reset (i_rst_n low, synchronous) empties both lists and clears overflow;
// list contents need no clearing pass.
module posting_list_intersect #(
    parameter int unsigned LIST_DEPTH = pli_pkg::LIST_DEPTH,
    parameter int unsigned ID_BITS    = pli_pkg::ID_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pli_pkg::OP_BITS-1:0]        i_op,
    input  logic [pli_pkg::DOC_ID_BITS-1:0]    i_doc_id,
    output logic                               o_strobe,
    output logic [pli_pkg::DOC_ID_BITS-1:0]    o_out_id,
    output logic                               o_is_last,
    output logic                               o_empty_answer,
    output logic                               o_was_common,
    output logic                               o_overflow
);

    pli_pkg::t_cmd  cmd;
    pli_pkg::t_stat stat;

    // sequencer
    pli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // lists, buffers and result register
    pli_dp #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_doc_id       (i_doc_id),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_strobe       (o_strobe),
        .o_out_id       (o_out_id),
        .o_is_last      (o_is_last),
        .o_empty_answer (o_empty_answer),
        .o_was_common   (o_was_common),
        .o_overflow     (o_overflow)
    );

endmodule

// ===== rtl/pli_checker.sv =====
module pli_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [pli_pkg::OP_BITS-1:0]        i_op,
    input logic                               o_strobe,
    input logic [pli_pkg::DOC_ID_BITS-1:0]    o_out_id,
    input logic                               o_is_last,
    input logic                               o_empty_answer,
    input logic                               o_was_common
);

    // results within one compute never come in adjacent cycles
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_is_last) |=> !o_strobe)
        else $error("back to back result strobes");

    // the empty answer is a single zero result
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_empty_answer) |->
            (o_is_last && (o_out_id == '0) && !o_was_common))
        else $error("malformed empty answer");

    // a compute request either starts work or answers at once
    a_compute_react: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == pli_pkg::OP_COMPUTE)) |=> (busy || o_strobe))
        else $error("compute request ignored");

    // a result shown while idle closes its compute
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !busy) |-> o_is_last)
        else $error("non-final result while idle");

    // busy ends in the cycle after the final result is shown
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_strobe && o_is_last))
        else $error("busy fell without final result");

endmodule

bind posting_list_intersect pli_checker u_pli_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_op           (i_op),
    .o_strobe       (o_strobe),
    .o_out_id       (o_out_id),
    .o_is_last      (o_is_last),
    .o_empty_answer (o_empty_answer),
    .o_was_common   (o_was_common)
);

// ===== test/posting_list_checker.sv =====
module posting_list_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic [pli_pkg::OP_BITS-1:0]     i_op,
    input  logic [pli_pkg::DOC_ID_BITS-1:0] i_doc_id,
    input  logic                            i_strobe,
    input  logic [pli_pkg::DOC_ID_BITS-1:0] i_out_id,
    input  logic                            i_is_last,
    input  logic                            i_empty_answer,
    input  logic                            i_was_common,
    input  logic                            i_overflow,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int unsigned DEPTH = pli_pkg::LIST_DEPTH;
    localparam logic [pli_pkg::DOC_ID_BITS-1:0] ID_MASK =
        (pli_pkg::ID_BITS >= pli_pkg::DOC_ID_BITS)
            ? {pli_pkg::DOC_ID_BITS{1'b1}}
            : ({pli_pkg::DOC_ID_BITS{1'b1}} >> (pli_pkg::DOC_ID_BITS - pli_pkg::ID_BITS));

    // one emitted id with its flags
    typedef struct packed {
        logic [pli_pkg::DOC_ID_BITS-1:0] id;
        logic                            last;
        logic                            empty;
        logic                            common;
        logic                            ovf;
    } t_id_result;

    // shadow copy of the two posting lists
    logic [pli_pkg::DOC_ID_BITS-1:0] first_ids  [DEPTH];
    logic [pli_pkg::DOC_ID_BITS-1:0] second_ids [DEPTH];
    int          first_len  = 0;
    int          second_len = 0;
    logic        dropped    = 1'b0;

    t_id_result  expected_ids [$];
    t_id_result  want;
    int          mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // two-pointer walk, merge fallback, sort, then queue the ids
    task automatic predict_compute();
        logic [pli_pkg::DOC_ID_BITS-1:0] hits [2*DEPTH];
        logic [pli_pkg::DOC_ID_BITS-1:0] key;
        t_id_result                      res;
        int                              n;
        int                              a;
        int                              b;
        int                              k;
        int                              j;
        logic                            found;
        n = 0;
        a = 0;
        b = 0;
        if (first_len == 0 && second_len == 0) begin
            res.id     = '0;
            res.last   = 1'b1;
            res.empty  = 1'b1;
            res.common = 1'b0;
            res.ovf    = dropped;
            expected_ids.insert(expected_ids.size(), res);
            return;
        end
        while (a < first_len && b < second_len) begin
            if (first_ids[a] == second_ids[b]) begin
                hits[n] = first_ids[a];
                n++;
                a++;
                b++;
            end else if (first_ids[a] > second_ids[b]) begin
                b++;
            end else begin
                a++;
            end
        end
        found = (n != 0);
        // nothing in common: take every id of both lists
        if (!found) begin
            for (k = 0; k < first_len; k++) begin
                hits[n] = first_ids[k];
                n++;
            end
            for (k = 0; k < second_len; k++) begin
                hits[n] = second_ids[k];
                n++;
            end
        end
        for (k = 1; k < n; k++) begin
            key = hits[k];
            j = k;
            while (j > 0 && hits[j-1] > key) begin
                hits[j] = hits[j-1];
                j--;
            end
            hits[j] = key;
        end
        for (k = 0; k < n; k++) begin
            res.id     = hits[k];
            res.last   = (k == n - 1);
            res.empty  = 1'b0;
            res.common = found;
            res.ovf    = dropped;
            expected_ids.insert(expected_ids.size(), res);
        end
        first_len  = 0;
        second_len = 0;
    endtask

    // compare results first, then take the request of this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            first_len  = 0;
            second_len = 0;
            dropped    = 1'b0;
            expected_ids.delete();
        end else begin
            if (i_strobe) begin
                if (expected_ids.size() == 0) begin
                    report_mismatch($sformatf("result id %0d with nothing expected",
                                              i_out_id));
                end else begin
                    want = expected_ids.pop_front();
                    if (i_out_id !== want.id)
                        report_mismatch($sformatf("out_id expected %0d got %0d",
                                                  want.id, i_out_id));
                    if (i_is_last !== want.last)
                        report_mismatch($sformatf("is_last expected %0b got %0b (id %0d)",
                                                  want.last, i_is_last, want.id));
                    if (i_empty_answer !== want.empty)
                        report_mismatch($sformatf("empty_answer expected %0b got %0b",
                                                  want.empty, i_empty_answer));
                    if (i_was_common !== want.common)
                        report_mismatch($sformatf("was_common expected %0b got %0b",
                                                  want.common, i_was_common));
                    if (i_overflow !== want.ovf)
                        report_mismatch($sformatf("overflow expected %0b got %0b",
                                                  want.ovf, i_overflow));
                end
            end
            if (i_start && !i_busy) begin
                case (i_op)
                    pli_pkg::OP_APPEND_A: begin
                        if (first_len < DEPTH) begin
                            first_ids[first_len] = i_doc_id & ID_MASK;
                            first_len++;
                        end else begin
                            dropped = 1'b1;
                        end
                    end
                    pli_pkg::OP_APPEND_B: begin
                        if (second_len < DEPTH) begin
                            second_ids[second_len] = i_doc_id & ID_MASK;
                            second_len++;
                        end else begin
                            dropped = 1'b1;
                        end
                    end
                    pli_pkg::OP_COMPUTE: begin
                        predict_compute();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= expected_ids.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== test/posting_list_intersect_tb.sv =====
module posting_list_intersect_tb;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int ITEM_TARGET    = 370;
    localparam int CALM_TAIL      = 60;
    localparam int MAX_LOADS      = 40;

    localparam logic [pli_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

    // id patterns for one query
    localparam int MODE_OVERLAP  = 0;
    localparam int MODE_PARITY   = 1;
    localparam int MODE_SCRAMBLE = 2;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [pli_pkg::OP_BITS-1:0]     i_op;
    logic [pli_pkg::DOC_ID_BITS-1:0] i_doc_id;
    logic                            o_strobe;
    logic [pli_pkg::DOC_ID_BITS-1:0] o_out_id;
    logic                            o_is_last;
    logic                            o_empty_answer;
    logic                            o_was_common;
    logic                            o_overflow;
    int                              fail_count;
    int                              pending;

    int                              items_sent  = 0;
    int                              idle_odds   = 0;
    int                              idle_cycles = 0;
    logic [pli_pkg::DOC_ID_BITS-1:0] load_a [MAX_LOADS];
    logic [pli_pkg::DOC_ID_BITS-1:0] load_b [MAX_LOADS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    posting_list_intersect u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_doc_id       (i_doc_id),
        .o_strobe       (o_strobe),
        .o_out_id       (o_out_id),
        .o_is_last      (o_is_last),
        .o_empty_answer (o_empty_answer),
        .o_was_common   (o_was_common),
        .o_overflow     (o_overflow)
    );

    posting_list_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (i_op),
        .i_doc_id       (i_doc_id),
        .i_strobe       (o_strobe),
        .i_out_id       (o_out_id),
        .i_is_last      (o_is_last),
        .i_empty_answer (o_empty_answer),
        .i_was_common   (o_was_common),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // watchdog on cycles with no request taken and no result shown
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // hold one request until taken, then maybe go quiet for a burst
    task automatic send_request(input logic [pli_pkg::OP_BITS-1:0] op,
                                input logic [pli_pkg::DOC_ID_BITS-1:0] id);
        start    <= 1'b1;
        i_op     <= op;
        i_doc_id <= id;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if (op != OP_UNUSED) items_sent++;
        if (items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(1, 8) <= idle_odds) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // stop sending until every queued result has shown up
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic int pick_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(30, pli_pkg::LIST_DEPTH + 2);
        return $urandom_range(0, 8);
    endfunction

    // build both lists, load them interleaved with some noise, then compute
    task automatic run_query(input int len_a, input int len_b, input int mode);
        int cur_a;
        int cur_b;
        int ia;
        int ib;
        int k;
        case (mode)
            MODE_OVERLAP: begin
                cur_a = ($urandom_range(0, 3) == 0) ? $urandom_range(65400, 65535)
                                                    : $urandom_range(0, 65000);
                cur_b = cur_a;
            end
            MODE_PARITY: begin
                cur_a = 2 * $urandom_range(0, 32000);
                cur_b = cur_a + 1;
            end
            default: begin
                cur_a = 0;
                cur_b = 0;
            end
        endcase
        for (k = 0; k < MAX_LOADS; k++) begin
            if (mode == MODE_SCRAMBLE) begin
                load_a[k] = 16'($urandom_range(0, 65535));
                load_b[k] = 16'($urandom_range(0, 65535));
            end else begin
                load_a[k] = cur_a[15:0];
                load_b[k] = cur_b[15:0];
                if (mode == MODE_OVERLAP) begin
                    cur_a = cur_a + $urandom_range(0, 3);
                    cur_b = cur_b + $urandom_range(0, 3);
                end else begin
                    cur_a = cur_a + 2 * $urandom_range(1, 3);
                    cur_b = cur_b + 2 * $urandom_range(1, 3);
                end
                if (cur_a > 65535) cur_a = 65535;
                if (cur_b > 65535) cur_b = 65535;
            end
        end
        ia = 0;
        ib = 0;
        while (ia < len_a || ib < len_b) begin
            if ($urandom_range(0, 15) == 0)
                send_request(OP_UNUSED, 16'($urandom_range(0, 65535)));
            if (ib >= len_b || (ia < len_a && $urandom_range(0, 1) == 1)) begin
                send_request(pli_pkg::OP_APPEND_A, load_a[ia]);
                ia++;
            end else begin
                send_request(pli_pkg::OP_APPEND_B, load_b[ib]);
                ib++;
            end
        end
        send_request(pli_pkg::OP_COMPUTE, 16'($urandom_range(0, 65535)));
    endtask

    initial begin
        int   query_no;
        int   len_a;
        int   len_b;
        int   roll;
        int   mode;
        logic overflow_forced;
        query_no        = 0;
        overflow_forced = 1'b0;
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_op     <= pli_pkg::OP_APPEND_A;
        i_doc_id <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty answer, ignored op, extremes, one list empty,
        // unsorted loads, match found, merge fallback
        idle_odds = 2;
        send_request(pli_pkg::OP_COMPUTE, 16'hFFFF);
        send_request(OP_UNUSED, 16'hFFFF);
        send_request(pli_pkg::OP_COMPUTE, 16'h0000);
        send_request(pli_pkg::OP_APPEND_A, 16'h0000);
        send_request(pli_pkg::OP_APPEND_A, 16'hFFFF);
        send_request(pli_pkg::OP_APPEND_B, 16'hFFFF);
        send_request(pli_pkg::OP_COMPUTE, 16'h1234);
        send_request(pli_pkg::OP_APPEND_A, 16'h0000);
        send_request(pli_pkg::OP_COMPUTE, 16'h0000);
        send_request(pli_pkg::OP_APPEND_B, 16'd7);
        send_request(pli_pkg::OP_APPEND_B, 16'd3);
        send_request(pli_pkg::OP_COMPUTE, 16'hFFFF);
        send_request(pli_pkg::OP_APPEND_A, 16'd5);
        send_request(pli_pkg::OP_APPEND_A, 16'd1);
        send_request(pli_pkg::OP_APPEND_A, 16'd9);
        send_request(pli_pkg::OP_APPEND_B, 16'd1);
        send_request(pli_pkg::OP_APPEND_B, 16'd9);
        send_request(pli_pkg::OP_COMPUTE, 16'h0000);
        send_request(pli_pkg::OP_APPEND_A, 16'h5555);
        send_request(pli_pkg::OP_APPEND_B, 16'hAAAA);
        send_request(pli_pkg::OP_COMPUTE, 16'h5555);
        wait_for_results();

        // random queries, mostly sorted lists that share ids
        while (items_sent < ITEM_TARGET) begin
            idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
            len_a = pick_length();
            len_b = pick_length();
            if (!overflow_forced && items_sent > ITEM_TARGET / 2) begin
                len_a = pli_pkg::LIST_DEPTH + 2;
                overflow_forced = 1'b1;
            end
            roll = $urandom_range(0, 9);
            if (roll < 5)
                mode = MODE_OVERLAP;
            else if (roll < 8)
                mode = MODE_PARITY;
            else
                mode = MODE_SCRAMBLE;
            run_query(len_a, len_b, mode);
            query_no++;
            if (query_no % 8 == 0) wait_for_results();
        end

        wait_for_results();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pli_pkg.sv
rtl/pli_ctrl.sv
rtl/pli_dp.sv
rtl/posting_list_intersect.sv
rtl/pli_checker.sv
test/posting_list_checker.sv
test/posting_list_intersect_tb.sv
